/* sv/median_ema_temperature_conditioner_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the temperature conditioner
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef MEDIAN_EMA_TEMPERATURE_CONDITIONER_ASSERT_SVH
`define MEDIAN_EMA_TEMPERATURE_CONDITIONER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MTC_ASSERT_IMPLY(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("mtc: same-cycle check failed");
// next-cycle implication
`define MTC_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("mtc: next-cycle check failed");
`else
`define MTC_ASSERT_IMPLY(label, clock, resetn, ante, cons)
`define MTC_ASSERT_NEXT(label, clock, resetn, ante, cons)
`endif
`endif

/* sv/mtc_pkg.sv */
// ---------------------------------------------------------------------------
// mtc_pkg
// Shared widths, register codes and types of the temperature conditioner.
// ---------------------------------------------------------------------------
`default_nettype none

package mtc_pkg;

    // field widths
    localparam int SAMPLE_W   = 12;
    localparam int HELD_W     = 13;
    localparam int AVG_W      = 29;
    localparam int FRAC_W     = 16;
    localparam int ALPHA_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int OFFSET_W   = 14;
    localparam int LIMIT_W    = 4;
    localparam int CAL_W      = 16;
    localparam int CAL_FRAC_W = 12;

    // configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_GAIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_OFFSET    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT = 2'd3;

    localparam logic [ALPHA_W-1:0]         RST_EMA_ALPHA   = 16'd3121;
    localparam logic [GAIN_W-1:0]          RST_TRIM_GAIN   = 16'd4096;
    localparam logic signed [OFFSET_W-1:0] RST_TRIM_OFFSET = 14'sd0;
    localparam logic [LIMIT_W-1:0]         RST_LIMIT       = 4'd3;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [ALPHA_W-1:0]         ema_alpha;
        logic [GAIN_W-1:0]          trim_gain;
        logic signed [OFFSET_W-1:0] trim_offset;
        logic [LIMIT_W-1:0]         limit;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       bad;
        logic                       fault;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_beat_t;

    typedef struct packed {
        logic pop;
        logic busy;
    } back_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOAD,
        BK_MEDIAN,
        BK_MUL,
        BK_ACC,
        BK_HOLD,
        BK_CAL,
        BK_OUT
    } back_state_t;

endpackage

`default_nettype wire

/* sv/mtc_front.sv */
// ---------------------------------------------------------------------------
// mtc_front
// Accepts readings, debounces the fault run and pushes beats to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module mtc_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [mtc_pkg::SAMPLE_W-1:0] temp_sample,
    input  wire logic                                read_fault,
    input  wire mtc_pkg::cfg_t                       cfg,
    input  wire logic                                q_full,
    output mtc_pkg::q_beat_t                         push
);

    logic                          accept;
    logic [mtc_pkg::LIMIT_W-1:0]   bad_run_reg;
    logic [mtc_pkg::LIMIT_W-1:0]   bad_run_next;

    // stall only on a full queue
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // saturating run of bad reads, cleared by a good read
    always_comb
    begin
        bad_run_next = bad_run_reg;
        if (accept)
        begin
            if (!read_fault)
                bad_run_next = '0;
            else if (bad_run_reg < cfg.limit)
                bad_run_next = bad_run_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bad_run_reg <= '0;
        else
            bad_run_reg <= bad_run_next;
    end

    // classified beat for the back end
    assign push.valid        = accept;
    assign push.entry.sample = temp_sample;
    assign push.entry.bad    = read_fault;
    assign push.entry.fault  = (bad_run_next >= cfg.limit);

endmodule

`default_nettype wire

/* sv/mtc_queue.sv */
// ---------------------------------------------------------------------------
// mtc_queue
// Short FIFO between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module mtc_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mtc_pkg::q_beat_t push,
    input  wire logic             pop,
    output mtc_pkg::q_beat_t      head,
    output logic                  full
);

    localparam logic [mtc_pkg::QPTR_W-1:0] LAST_PTR = mtc_pkg::QPTR_W'(mtc_pkg::QUEUE_DEPTH - 1);
    localparam logic [mtc_pkg::QPTR_W:0]   FULL_CNT = (mtc_pkg::QPTR_W + 1)'(mtc_pkg::QUEUE_DEPTH);

    mtc_pkg::q_entry_t             slot_reg [mtc_pkg::QUEUE_DEPTH];
    logic [mtc_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [mtc_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [mtc_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [mtc_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [mtc_pkg::QPTR_W:0]      count_reg;
    logic [mtc_pkg::QPTR_W:0]      count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head.valid = (count_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push.valid && !pop)
            count_next = count_reg + 1'b1;
        else if (!push.valid && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
            slot_reg[wr_ptr_reg] <= push.entry;
    end

endmodule

`default_nettype wire

/* sv/mtc_back.sv */
// ---------------------------------------------------------------------------
// mtc_back
// Sample ring, median select, moving average, calibration and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module mtc_back #(
    parameter int MEDIAN_DEPTH = 5
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mtc_pkg::cfg_t                     cfg,
    input  wire mtc_pkg::q_beat_t                  head,
    output mtc_pkg::back_status_t                  status,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   fault_flag,
    output logic signed [mtc_pkg::SAMPLE_W-1:0]    filtered_temp,
    output logic signed [mtc_pkg::CAL_W-1:0]       calibrated_temp
);

    localparam int RING_IDX_W = $clog2(MEDIAN_DEPTH);
    localparam int FILL_W     = $clog2(MEDIAN_DEPTH + 1);
    localparam int SW         = mtc_pkg::SAMPLE_W;
    localparam int AW         = mtc_pkg::AVG_W;
    localparam int FW         = mtc_pkg::FRAC_W;
    localparam int HW         = mtc_pkg::HELD_W;
    localparam int DIFF_W     = AW + 1;
    localparam int PROD_W     = DIFF_W + mtc_pkg::ALPHA_W + 1;
    localparam int STEP_W     = PROD_W - FW;
    localparam int ASUM_W     = STEP_W;
    localparam int CPROD_W    = mtc_pkg::GAIN_W + 1 + HW;
    localparam int CSHIFT_W   = CPROD_W - mtc_pkg::CAL_FRAC_W;
    localparam int CSUM_W     = CSHIFT_W + 1;

    localparam logic [RING_IDX_W-1:0] LAST_IDX = RING_IDX_W'(MEDIAN_DEPTH - 1);
    localparam logic [FILL_W-1:0]     FULL_FILL = FILL_W'(MEDIAN_DEPTH);
    localparam logic signed [PROD_W-1:0]  PROD_HALF = PROD_W'(1 << (FW - 1));
    localparam logic signed [DIFF_W-1:0]  AVG_HALF  = DIFF_W'(1 << (FW - 1));
    localparam logic signed [CPROD_W-1:0] CAL_HALF  = CPROD_W'(1 << (mtc_pkg::CAL_FRAC_W - 1));
    localparam logic signed [CSUM_W-1:0]  CAL_MAX   = CSUM_W'(32767);
    localparam logic signed [CSUM_W-1:0]  CAL_MIN   = -CSUM_W'(32768);

    mtc_pkg::back_state_t          state_reg;
    mtc_pkg::back_state_t          state_next;

    // control strobes
    logic                          out_free;
    logic                          do_pop;
    logic                          do_load;
    logic                          do_median;
    logic                          do_mul;
    logic                          do_acc;
    logic                          do_hold;
    logic                          do_cal;
    logic                          do_out;

    // work registers
    logic signed [SW-1:0]          ring_reg [MEDIAN_DEPTH];
    logic [RING_IDX_W-1:0]         wr_idx_reg;
    logic [FILL_W-1:0]             fill_reg;
    logic signed [SW-1:0]          sample_reg;
    logic                          fault_reg;
    logic signed [SW-1:0]          med_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [AW-1:0]          avg_reg;
    logic                          seeded_reg;
    logic signed [HW-1:0]          held_reg;
    logic signed [CPROD_W-1:0]     cprod_reg;
    logic                          out_valid_reg;
    logic                          out_fault_reg;
    logic signed [SW-1:0]          out_filt_reg;
    logic signed [mtc_pkg::CAL_W-1:0] out_cal_reg;

    // datapath nets
    logic [FILL_W-1:0]             rank;
    logic signed [SW-1:0]          med_sel;
    logic signed [DIFF_W-1:0]      diff;
    logic signed [PROD_W-1:0]      prod_rnd;
    logic signed [ASUM_W-1:0]      avg_sum;
    logic signed [DIFF_W-1:0]      avg_rnd;
    logic signed [CPROD_W-1:0]     cprod_rnd;
    logic signed [CSUM_W-1:0]      cal_sum;
    logic signed [mtc_pkg::CAL_W-1:0] cal_sat;

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtc_pkg::BK_IDLE:
                if (head.valid)
                    state_next = head.entry.bad ? mtc_pkg::BK_CAL : mtc_pkg::BK_LOAD;
            mtc_pkg::BK_LOAD:   state_next = mtc_pkg::BK_MEDIAN;
            mtc_pkg::BK_MEDIAN: state_next = mtc_pkg::BK_MUL;
            mtc_pkg::BK_MUL:
                state_next = seeded_reg ? mtc_pkg::BK_ACC : mtc_pkg::BK_HOLD;
            mtc_pkg::BK_ACC:    state_next = mtc_pkg::BK_HOLD;
            mtc_pkg::BK_HOLD:   state_next = mtc_pkg::BK_CAL;
            mtc_pkg::BK_CAL:    state_next = mtc_pkg::BK_OUT;
            mtc_pkg::BK_OUT:
                if (out_free)
                    state_next = mtc_pkg::BK_IDLE;
            default:            state_next = mtc_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        do_pop    = 1'b0;
        do_load   = 1'b0;
        do_median = 1'b0;
        do_mul    = 1'b0;
        do_acc    = 1'b0;
        do_hold   = 1'b0;
        do_cal    = 1'b0;
        do_out    = 1'b0;
        case (state_reg)
            mtc_pkg::BK_IDLE:   do_pop    = head.valid;
            mtc_pkg::BK_LOAD:   do_load   = 1'b1;
            mtc_pkg::BK_MEDIAN: do_median = 1'b1;
            mtc_pkg::BK_MUL:    do_mul    = 1'b1;
            mtc_pkg::BK_ACC:    do_acc    = 1'b1;
            mtc_pkg::BK_HOLD:   do_hold   = 1'b1;
            mtc_pkg::BK_CAL:    do_cal    = 1'b1;
            mtc_pkg::BK_OUT:    do_out    = out_free;
            default:            do_pop    = 1'b0;
        endcase
    end

    assign status.pop  = do_pop;
    assign status.busy = (state_reg != mtc_pkg::BK_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mtc_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    // median by rank: ties broken by slot index, only loaded slots count
    always_comb
    begin
        med_sel = '0;
        rank    = '0;
        for (int i = 0; i < MEDIAN_DEPTH; i++)
        begin
            rank = '0;
            for (int j = 0; j < MEDIAN_DEPTH; j++)
            begin
                if ((FILL_W'(j) < fill_reg) &&
                    ((ring_reg[j] < ring_reg[i]) || ((ring_reg[j] == ring_reg[i]) && (j < i))))
                    rank = rank + 1'b1;
            end
            if ((FILL_W'(i) < fill_reg) && (rank == (fill_reg >> 1)))
                med_sel = ring_reg[i];
        end
    end

    // average arithmetic
    assign diff      = $signed({{(DIFF_W - SW - FW){med_reg[SW-1]}}, med_reg, {FW{1'b0}}})
                       - $signed({avg_reg[AW-1], avg_reg});
    assign prod_rnd  = prod_reg + PROD_HALF;
    assign avg_sum   = $signed({{(ASUM_W - AW){avg_reg[AW-1]}}, avg_reg})
                       + $signed(prod_rnd[PROD_W-1:FW]);
    assign avg_rnd   = $signed({avg_reg[AW-1], avg_reg}) + AVG_HALF;

    // calibration round, offset and saturate
    assign cprod_rnd = cprod_reg + CAL_HALF;
    assign cal_sum   = $signed({cprod_rnd[CPROD_W-1], cprod_rnd[CPROD_W-1:mtc_pkg::CAL_FRAC_W]})
                       + $signed({{(CSUM_W - mtc_pkg::OFFSET_W)
                                   {cfg.trim_offset[mtc_pkg::OFFSET_W-1]}},
                                  cfg.trim_offset});

    always_comb
    begin
        if (cal_sum > CAL_MAX)
            cal_sat = {1'b0, {(mtc_pkg::CAL_W - 1){1'b1}}};
        else if (cal_sum < CAL_MIN)
            cal_sat = {1'b1, {(mtc_pkg::CAL_W - 1){1'b0}}};
        else
            cal_sat = cal_sum[mtc_pkg::CAL_W-1:0];
    end

    // stored state of the filter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            fill_reg   <= '0;
            avg_reg    <= '0;
            seeded_reg <= 1'b0;
            held_reg   <= '0;
        end
        else
        begin
            if (do_load)
            begin
                wr_idx_reg <= (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
                if (fill_reg != FULL_FILL)
                    fill_reg <= fill_reg + 1'b1;
            end
            if (do_mul && !seeded_reg)
            begin
                avg_reg    <= $signed({med_reg[SW-1], med_reg, {FW{1'b0}}});
                seeded_reg <= 1'b1;
            end
            if (do_acc)
                avg_reg <= avg_sum[AW-1:0];
            if (do_hold)
                held_reg <= avg_rnd[FW+HW-1:FW];
        end
    end

    // payload pipeline registers
    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            sample_reg <= head.entry.sample;
            fault_reg  <= head.entry.fault;
        end
        if (do_load)
            ring_reg[wr_idx_reg] <= sample_reg;
        if (do_median)
            med_reg <= med_sel;
        if (do_mul)
            prod_reg <= diff * $signed({1'b0, cfg.ema_alpha});
        if (do_cal)
            cprod_reg <= $signed({1'b0, cfg.trim_gain}) * held_reg;
        if (do_out)
        begin
            out_fault_reg <= fault_reg;
            out_filt_reg  <= held_reg[SW-1:0];
            out_cal_reg   <= cal_sat;
        end
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (do_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid       = out_valid_reg;
    assign fault_flag      = out_fault_reg;
    assign filtered_temp   = out_filt_reg;
    assign calibrated_temp = out_cal_reg;

endmodule

`default_nettype wire

/* sv/median_ema_temperature_conditioner.sv */
// The back end works on one reading at a time: a good reading passes pop, ring write, rank
// select, alpha multiply, accumulate (skipped when it seeds the average), round, gain
// multiply and output; a bad one passes pop, gain multiply and output. A 2-beat queue lets
// the front accept while the back is busy.
// Reset (rst_n low, asynchronous): control, average and held value clear, registers take
// their defaults; the sample ring is not cleared, its fill count guards unwritten slots.
// ---------------------------------------------------------------------------
// median_ema_temperature_conditioner
// Debounced fault, median of recent good readings, moving average, calibration.
// ---------------------------------------------------------------------------
`default_nettype none

`include "median_ema_temperature_conditioner_assert.svh"

module median_ema_temperature_conditioner #(
    parameter int MEDIAN_DEPTH = 5
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [mtc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [mtc_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [mtc_pkg::SAMPLE_W-1:0]    temp_sample,
    input  wire logic                                   read_fault,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic                                        fault_flag,
    output logic signed [mtc_pkg::SAMPLE_W-1:0]         filtered_temp,
    output logic signed [mtc_pkg::CAL_W-1:0]            calibrated_temp
);

    mtc_pkg::cfg_t         cfg_reg;
    mtc_pkg::q_beat_t      q_push;
    mtc_pkg::q_beat_t      q_head;
    logic                  q_full;
    mtc_pkg::back_status_t bk_status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ema_alpha   <= mtc_pkg::RST_EMA_ALPHA;
            cfg_reg.trim_gain   <= mtc_pkg::RST_TRIM_GAIN;
            cfg_reg.trim_offset <= mtc_pkg::RST_TRIM_OFFSET;
            cfg_reg.limit       <= mtc_pkg::RST_LIMIT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mtc_pkg::CFG_EMA_ALPHA:
                    cfg_reg.ema_alpha <= cfg_data[mtc_pkg::ALPHA_W-1:0];
                mtc_pkg::CFG_TRIM_GAIN:
                    cfg_reg.trim_gain <= cfg_data[mtc_pkg::GAIN_W-1:0];
                mtc_pkg::CFG_TRIM_OFFSET:
                    cfg_reg.trim_offset <= $signed(cfg_data[mtc_pkg::OFFSET_W-1:0]);
                mtc_pkg::CFG_DEBOUNCE_LIMIT:
                    cfg_reg.limit <= cfg_data[mtc_pkg::LIMIT_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front end
    mtc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .temp_sample (temp_sample),
        .read_fault  (read_fault),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .push        (q_push)
    );

    // decoupling queue
    mtc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .pop   (bk_status.pop),
        .head  (q_head),
        .full  (q_full)
    );

    // back end
    mtc_back #(
        .MEDIAN_DEPTH (MEDIAN_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .head            (q_head),
        .status          (bk_status),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .fault_flag      (fault_flag),
        .filtered_temp   (filtered_temp),
        .calibrated_temp (calibrated_temp)
    );

    // back end never pops an empty queue
    `MTC_ASSERT_IMPLY(a_pop_needs_head, clk, rst_n, bk_status.pop, q_head.valid)
    // a beat accepted into an empty queue shows at the head next cycle
    `MTC_ASSERT_NEXT(a_push_lands, clk, rst_n, in_valid && !in_stall && !q_head.valid, q_head.valid)
    // a result only appears after the back end worked on it
    `MTC_ASSERT_IMPLY(a_out_from_back, clk, rst_n, $rose(out_valid), $past(bk_status.busy))

endmodule

`default_nettype wire

/* dv/median_ema_temperature_conditioner_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// median_ema_temperature_conditioner_tb
// Drives temperature readings with random idle gaps and output stalls, walks
// through a set of register settings, and compares every result beat with a
// cycle-free prediction of the debounce, median, average and calibration path.
// ---------------------------------------------------------------------------
module median_ema_temperature_conditioner_tb;

    localparam int  RING_DEPTH  = 5;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  SETTLE      = 12;
    localparam int  FINAL_WAIT  = 20;
    localparam int  NUM_PHASES  = 10;
    localparam int  PHASE_BEATS = 125;

    // one expected result beat
    typedef struct {
        logic                                fault;
        logic signed [mtc_pkg::SAMPLE_W-1:0] filtered;
        logic signed [mtc_pkg::CAL_W-1:0]    calibrated;
    } reading_result_t;

    // ---------------------------------------------------------------------
    // Conditioner prediction and result checking
    // ---------------------------------------------------------------------
    class conditioner_scoreboard;
        longint          alpha;
        longint          gain;
        longint          offset;
        longint          limit;
        int              ring[RING_DEPTH];
        int              wr_idx;
        int              fill;
        longint          average;
        bit              seeded;
        longint          bad_run;
        int              held;
        reading_result_t due[$];
        int              errors;

        function new();
            alpha   = mtc_pkg::RST_EMA_ALPHA;
            gain    = mtc_pkg::RST_TRIM_GAIN;
            offset  = mtc_pkg::RST_TRIM_OFFSET;
            limit   = mtc_pkg::RST_LIMIT;
            wr_idx  = 0;
            fill    = 0;
            average = 0;
            seeded  = 0;
            bad_run = 0;
            held    = 0;
            errors  = 0;
            foreach (ring[i]) ring[i] = 0;
        endfunction

        function void set_register(logic [mtc_pkg::CFG_IDX_W-1:0] idx,
                                   logic [mtc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                mtc_pkg::CFG_EMA_ALPHA:      alpha  = data[mtc_pkg::ALPHA_W-1:0];
                mtc_pkg::CFG_TRIM_GAIN:      gain   = data[mtc_pkg::GAIN_W-1:0];
                mtc_pkg::CFG_TRIM_OFFSET:    offset = $signed(data[mtc_pkg::OFFSET_W-1:0]);
                mtc_pkg::CFG_DEBOUNCE_LIMIT: limit  = data[mtc_pkg::LIMIT_W-1:0];
                default:                     ;
            endcase
        endfunction

        // median of the loaded entries, upper median for an even count
        function int ring_median();
            int sorted[RING_DEPTH];
            int n;
            int v;
            int j;
            n = fill;
            for (int i = 0; i < n; i++) sorted[i] = ring[i];
            for (int i = 1; i < n; i++)
            begin
                v = sorted[i];
                j = i;
                while (j > 0 && sorted[j-1] > v)
                begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = v;
            end
            return sorted[n/2];
        endfunction

        function void note_reading(logic signed [mtc_pkg::SAMPLE_W-1:0] sample, logic bad);
            reading_result_t r;
            longint          diff;
            longint          cal;
            int              med;
            if (bad)
            begin
                if (bad_run < limit) bad_run++;
            end
            else
            begin
                bad_run = 0;
                ring[wr_idx] = sample;
                wr_idx = (wr_idx + 1) % RING_DEPTH;
                if (fill < RING_DEPTH) fill++;
                med = ring_median();
                if (!seeded)
                begin
                    average = longint'(med) * 65536;
                    seeded  = 1;
                end
                else
                begin
                    diff = longint'(med) * 65536 - average;
                    average += (diff * alpha + 32768) >>> mtc_pkg::FRAC_W;
                end
                held = int'((average + 32768) >>> mtc_pkg::FRAC_W);
            end
            cal = ((gain * held + 2048) >>> mtc_pkg::CAL_FRAC_W) + offset;
            if (cal > 32767) cal = 32767;
            if (cal < -32768) cal = -32768;
            r.fault      = (bad_run >= limit);
            r.filtered   = held[mtc_pkg::SAMPLE_W-1:0];
            r.calibrated = cal[mtc_pkg::CAL_W-1:0];
            due.push_back(r);
        endfunction

        function void check_result(logic fault, logic signed [mtc_pkg::SAMPLE_W-1:0] filtered,
                                   logic signed [mtc_pkg::CAL_W-1:0] calibrated);
            reading_result_t r;
            if (due.size() == 0)
            begin
                $error("result beat with nothing expected: fault_flag=%0b filtered_temp=%0d",
                       fault, filtered);
                errors++;
                return;
            end
            r = due.pop_front();
            if (fault !== r.fault)
            begin
                $error("fault_flag: expected %0b, got %0b", r.fault, fault);
                errors++;
            end
            if (filtered !== r.filtered)
            begin
                $error("filtered_temp: expected %0d, got %0d", r.filtered, filtered);
                errors++;
            end
            if (calibrated !== r.calibrated)
            begin
                $error("calibrated_temp: expected %0d, got %0d", r.calibrated, calibrated);
                errors++;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    // ---------------------------------------------------------------------
    // Signals and DUT
    // ---------------------------------------------------------------------
    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_wr_en = 1'b0;
    logic [mtc_pkg::CFG_IDX_W-1:0]        cfg_index = mtc_pkg::CFG_EMA_ALPHA;
    logic [mtc_pkg::CFG_DATA_W-1:0]       cfg_data = '0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic signed [mtc_pkg::SAMPLE_W-1:0]  temp_sample = '0;
    logic                                 read_fault = 1'b0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic                                 fault_flag;
    logic signed [mtc_pkg::SAMPLE_W-1:0]  filtered_temp;
    logic signed [mtc_pkg::CAL_W-1:0]     calibrated_temp;

    conditioner_scoreboard book = new();

    int  cycles = 0;
    bit  calm = 0;          // no idling on either side while set
    int  out_hold = 0;
    int  level = 400;
    int  bad_left = 0;

    median_ema_temperature_conditioner #(.MEDIAN_DEPTH(RING_DEPTH)) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .temp_sample     (temp_sample),
        .read_fault      (read_fault),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .fault_flag      (fault_flag),
        .filtered_temp   (filtered_temp),
        .calibrated_temp (calibrated_temp)
    );

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function int idle_cycles();
        if (calm) return 0;
        return $urandom_range(0, 9);
    endfunction

    // ---------------------------------------------------------------------
    // Result side: check accepted beats, stall for a random count after each
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                book.check_result(fault_flag, filtered_temp, calibrated_temp);
                out_hold = idle_cycles();
            end
            else if (out_hold > 0)
                out_hold--;
            out_stall <= (out_hold != 0);
        end
    end

    // ---------------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------------
    // one reading beat; valid stays high when the next beat follows at once
    task automatic send_reading(input logic signed [mtc_pkg::SAMPLE_W-1:0] sample,
                                input logic bad);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        temp_sample <= sample;
        read_fault  <= bad;
        do @(posedge clk); while (in_stall);
        book.note_reading(sample, bad);
    endtask

    // lower valid and wait until every expected beat is in, then settle
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        while (book.pending() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mtc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mtc_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        book.set_register(idx, data);
    endtask

    // unused upper data bits carry random junk
    task automatic write_settings(input int alpha, input int gain, input int offset,
                                  input int limit);
        logic [31:0] junk;
        logic [31:0] off_bits;
        logic [31:0] lim_bits;
        junk     = $urandom;
        off_bits = offset;
        lim_bits = limit;
        write_reg(mtc_pkg::CFG_EMA_ALPHA, alpha[15:0]);
        write_reg(mtc_pkg::CFG_TRIM_GAIN, gain[15:0]);
        write_reg(mtc_pkg::CFG_TRIM_OFFSET, {junk[1:0], off_bits[13:0]});
        write_reg(mtc_pkg::CFG_DEBOUNCE_LIMIT, {junk[15:4], lim_bits[3:0]});
        cfg_wr_en <= 1'b0;
    endtask

    // mostly a noisy level with occasional bursts of failed reads
    task automatic run_random(input int count);
        logic [31:0] raw;
        int          v;
        logic        bad;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) == 0) calm = !calm;
            if ($urandom_range(0, 31) == 0) level = $urandom_range(0, 2880) - 880;
            if (bad_left == 0 && $urandom_range(0, 9) == 0)
                bad_left = $urandom_range(1, 18);
            bad = (bad_left > 0);
            if (bad_left > 0) bad_left--;
            raw = $urandom;
            if ($urandom_range(0, 3) == 0)
                v = $signed(raw[11:0]);
            else
            begin
                v = level + $urandom_range(0, 64) - 32;
                if (v > 2047) v = 2047;
                if (v < -2048) v = -2048;
            end
            send_reading(v[11:0], bad);
        end
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        int alpha_tab[1:4];
        int gain_tab[1:4];
        int offset_tab[1:4];
        int limit_tab[1:4];

        // extreme settings first, then random ones
        alpha_tab  = '{0, 65535, 1, 65535};
        gain_tab   = '{65535, 65535, 0, 4096};
        offset_tab = '{8191, -8192, -8192, 8191};
        limit_tab  = '{0, 15, 1, 15};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default registers: seeding, fill with even counts, extremes, debounce
        send_reading(12'sd0, 1'b0);
        send_reading(12'sd2047, 1'b0);
        send_reading(-12'sd2048, 1'b0);
        send_reading(-12'sd1, 1'b0);
        send_reading(12'sd1, 1'b0);
        send_reading(12'sd2000, 1'b0);
        send_reading(-12'sd880, 1'b0);
        send_reading(12'sd5, 1'b1);
        send_reading(-12'sd2048, 1'b1);
        send_reading(12'sd2047, 1'b1);
        send_reading(12'sd7, 1'b1);
        send_reading(12'sd100, 1'b0);
        send_reading(12'sd300, 1'b1);
        send_reading(-12'sd1, 1'b0);
        run_random(100);

        for (int p = 1; p < NUM_PHASES; p++)
        begin
            drain(SETTLE);
            if (p <= 4)
                write_settings(alpha_tab[p], gain_tab[p], offset_tab[p], limit_tab[p]);
            else
                write_settings($urandom_range(1, 65535), $urandom_range(0, 16383),
                               $urandom_range(0, 16383) - 8192, $urandom_range(0, 15));
            if (p == 1)
            begin
                // zero debounce limit and zero alpha
                send_reading(12'sd10, 1'b1);
                send_reading(-12'sd2048, 1'b0);
                send_reading(12'sd2047, 1'b0);
                send_reading(12'sd2047, 1'b1);
                send_reading(12'sd0, 1'b0);
            end
            run_random(PHASE_BEATS);
        end

        drain(FINAL_WAIT);
        if (book.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
